/* rtl/core/jsss_pkg.sv */
// jsss_pkg: shared types and constants of the joint step settle supervisor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package jsss_pkg;

    // configuration register widths and indexes
    localparam int RANGE_W = 22;
    localparam int TOL_W   = 16;
    localparam int VEL_W   = 21;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_TOL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_TOL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLDC_RANGE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DXL_RANGE  = 3'd4;

    // input commands
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // motor kinds
    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_BLDC  = 2'd1;
    localparam logic [1:0] KIND_DXL   = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    // result kinds
    localparam logic [1:0] RK_BLDC_CMD = 2'd0;
    localparam logic [1:0] RK_DXL_CMD  = 2'd1;
    localparam logic [1:0] RK_SUCCESS  = 2'd2;
    localparam logic [1:0] RK_TIMEOUT  = 2'd3;

    // electrical phase span of a bldc joint, hundredths of a degree
    localparam logic [RANGE_W-1:0] PHASE_SPAN = 22'd72000;

    localparam logic [TOL_W-1:0] CNT_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_POST,
        ST_NOM,
        ST_RAW,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        OP_TGT,
        OP_CUR,
        OP_ERR
    } op_t;

    // offset of raw target candidate k, k = idx - 2
    function automatic logic signed [19:0] cand_offset(input logic [2:0] idx);
        logic signed [19:0] off;
        case (idx)
            3'd0:    off = -20'sd144000;
            3'd1:    off = -20'sd72000;
            3'd2:    off = 20'sd0;
            3'd3:    off = 20'sd72000;
            default: off = 20'sd144000;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/joint_step_settle_supervisor.sv */
// joint_step_settle_supervisor: top level, step supervision with a shared
// bit-serial remainder unit; depends on jsss_pkg
`timescale 1ns / 1ps
`default_nettype none

// timing: start and sample items are taken while idle, and a dxl start then shows its command
// item; a tick holds s_ready low through two remainder runs and the raw target search on a bldc
// step, three remainder runs otherwise, and while its results wait on m_ready
// throughput: one item at a time; results leave from an output register, up to two per tick
// reset: synchronous active-low aresetn clears control state, both joint stores
// and loads the configuration defaults

module joint_step_settle_supervisor #(
    parameter int NUM_MOTORS = 4,
    parameter int ANGLE_BITS = 24
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // configuration write port
    input  wire                              cfg_we,
    input  wire [jsss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [jsss_pkg::RANGE_W-1:0]      cfg_wdata,
    // input item channel
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire [1:0]                        s_command,
    input  wire [3:0]                        s_motor_number,
    input  wire [1:0]                        s_motor_kind,
    input  wire signed [ANGLE_BITS-1:0]      s_target_angle,
    input  wire [15:0]                       s_timeout_ticks,
    input  wire signed [ANGLE_BITS-1:0]      s_sample_angle,
    input  wire signed [jsss_pkg::VEL_W-1:0] s_sample_velocity,
    // result item channel
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [1:0]                       m_result_kind,
    output logic [3:0]                       m_result_motor,
    output logic signed [ANGLE_BITS-1:0]     m_result_angle,
    output logic                             m_last_of_run
);

    localparam int DW = jsss_pkg::RANGE_W;
    localparam int TW = jsss_pkg::TOL_W;
    localparam int VW = jsss_pkg::VEL_W;
    // dividend width: holds any angle and any difference of wrapped values
    localparam int WA = ((ANGLE_BITS > DW) ? ANGLE_BITS : DW) + 2;
    // raw target candidate width
    localparam int WR = WA + 2;
    localparam int CW = $clog2(WA + 1);
    localparam int MI = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

    // configuration
    logic [TW-1:0] pos_tol_reg, pos_tol_next;
    logic [TW-1:0] vel_tol_reg, vel_tol_next;
    logic [TW-1:0] settle_ticks_reg, settle_ticks_next;
    logic [DW-1:0] bldc_range_reg, bldc_range_next;
    logic [DW-1:0] dxl_range_reg, dxl_range_next;

    // step state
    logic                         armed_reg, armed_next;
    logic [3:0]                   motor_reg, motor_next;
    logic [1:0]                   kind_reg, kind_next;
    logic signed [ANGLE_BITS-1:0] target_reg, target_next;
    logic [TW-1:0]                timeout_reg, timeout_next;
    logic [TW-1:0]                elapsed_reg, elapsed_next;
    logic                         settling_reg, settling_next;
    logic [TW-1:0]                settle_cnt_reg, settle_cnt_next;

    // joint stores
    logic signed [ANGLE_BITS-1:0] angle_store_reg [NUM_MOTORS];
    logic signed [VW-1:0]         vel_store_reg   [NUM_MOTORS];
    logic                         store_we;
    logic [MI-1:0]                store_idx;

    // sequencer and remainder unit
    jsss_pkg::state_t state_reg, state_next;
    jsss_pkg::op_t    op_reg, op_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WA-1:0]    dvd_reg, dvd_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic             neg_reg, neg_next;

    // tick working values
    logic signed [ANGLE_BITS-1:0] cur_reg, cur_next;
    logic signed [VW-1:0]         vel_reg, vel_next;
    logic [DW-1:0]                tgt_mod_reg, tgt_mod_next;
    logic signed [DW+1:0]         err_reg, err_next;
    logic signed [WR-1:0]         nominal_reg, nominal_next;
    logic [2:0]                   kidx_reg, kidx_next;
    logic                         found_reg, found_next;
    logic signed [WR-1:0]         best_reg, best_next;
    logic [WR-1:0]                bestd_reg, bestd_next;

    // output register and second pending result
    logic                         m_valid_reg, m_valid_next;
    logic [1:0]                   m_kind_reg, m_kind_next;
    logic signed [ANGLE_BITS-1:0] m_angle_reg, m_angle_next;
    logic                         m_last_reg, m_last_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [1:0]                   pend_kind_reg, pend_kind_next;

    // wrap span of the current remainder: phase span for bldc, else the
    // configured range, with zero acting as one
    logic [DW-1:0] span_eff;
    logic [DW-1:0] wrap_sel;
    logic          is_bldc;
    logic          active_ok;
    logic [3:0]    active_m1;
    logic [3:0]    sample_m1;
    logic          sample_ok;

    assign is_bldc   = (kind_reg == jsss_pkg::KIND_BLDC);
    assign wrap_sel  = (motor_reg == 4'd1 || motor_reg == 4'd2) ? bldc_range_reg : dxl_range_reg;
    assign span_eff  = is_bldc ? jsss_pkg::PHASE_SPAN
                               : ((wrap_sel == '0) ? DW'(1) : wrap_sel);
    assign active_ok = (motor_reg >= 4'd1) && (motor_reg <= 4'(NUM_MOTORS));
    assign active_m1 = motor_reg - 4'd1;
    assign sample_ok = (s_motor_number >= 4'd1) && (s_motor_number <= 4'(NUM_MOTORS));
    assign sample_m1 = s_motor_number - 4'd1;

    assign s_ready        = (state_reg == jsss_pkg::ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_kind  = m_kind_reg;
    assign m_result_motor = motor_reg;
    assign m_result_angle = m_angle_reg;
    assign m_last_of_run  = m_last_reg;

    // restoring remainder step, one dividend bit a cycle
    logic [DW:0]   rem_shift;
    logic          rem_ge;
    logic [DW-1:0] rem_step;

    assign rem_shift = {rem_reg, dvd_reg[WA-1]};
    assign rem_ge    = (rem_shift >= {1'b0, span_eff});
    assign rem_step  = rem_ge ? DW'(rem_shift - {1'b0, span_eff}) : rem_shift[DW-1:0];

    // remainder post processing: truncating signed result, nonnegative
    // modulo and fold into half a span either side
    logic signed [DW:0]   rem_signed;
    logic [DW-1:0]        rem_pos;
    logic signed [DW+1:0] fold_e;
    logic signed [DW+2:0] fold_e2;
    logic signed [DW+2:0] fold_sp;
    logic signed [DW+1:0] fold_res;

    always_comb begin
        rem_signed = neg_reg ? -$signed({1'b0, rem_reg}) : $signed({1'b0, rem_reg});
        rem_pos    = (neg_reg && rem_reg != '0) ? DW'(span_eff - rem_reg) : rem_reg;
        fold_e     = {rem_signed[DW], rem_signed};
        fold_e2    = {fold_e, 1'b0};
        fold_sp    = $signed({3'b000, span_eff});
        if (fold_e2 > fold_sp) begin
            fold_res = fold_e - $signed({2'b00, span_eff});
        end else if (fold_e2 < -fold_sp) begin
            fold_res = fold_e + $signed({2'b00, span_eff});
        end else begin
            fold_res = fold_e;
        end
    end

    // raw target candidate search, one candidate a cycle
    logic signed [WR-1:0] cand;
    logic signed [WR:0]   cand2;
    logic signed [WR:0]   range_s;
    logic                 cand_fits;
    logic signed [WR-1:0] cand_diff;
    logic [WR-1:0]        cand_dist;
    logic signed [WR-1:0] cur_wr;

    always_comb begin
        cur_wr    = WR'(cur_reg);
        cand      = nominal_reg + WR'(jsss_pkg::cand_offset(kidx_reg));
        cand2     = {cand, 1'b0};
        range_s   = $signed({{(WR + 1 - DW){1'b0}}, bldc_range_reg});
        cand_fits = !(cand2 < -range_s) && !(cand2 > range_s);
        cand_diff = cand - cur_wr;
        cand_dist = cand_diff[WR-1] ? WR'(-cand_diff) : cand_diff;
    end

    // tolerance checks and the raw target chosen
    logic [DW+1:0]        err_mag;
    logic [VW-1:0]        vel_mag;
    logic                 good;
    logic [TW-1:0]        settle_inc;
    logic                 success;
    logic                 timed_out;
    logic [DW-1:0]        half_range;
    logic signed [WR-1:0] raw_sel;

    always_comb begin
        err_mag    = err_reg[DW+1] ? (DW+2)'(-err_reg) : err_reg;
        vel_mag    = vel_reg[VW-1] ? VW'(-vel_reg) : vel_reg;
        good       = (err_mag <= (DW+2)'(pos_tol_reg)) && (vel_mag <= VW'(vel_tol_reg));
        settle_inc = (settle_cnt_reg == jsss_pkg::CNT_MAX) ? settle_cnt_reg
                                                           : settle_cnt_reg + 16'd1;
        success    = good && settling_reg && (settle_inc >= settle_ticks_reg);
        timed_out  = !success && (elapsed_reg >= timeout_reg);
        half_range = bldc_range_reg >> 1;
        if (found_reg) begin
            raw_sel = best_reg;
        end else if (nominal_reg < 0) begin
            raw_sel = -$signed({{(WR - DW){1'b0}}, half_range});
        end else begin
            raw_sel = $signed({{(WR - DW){1'b0}}, half_range});
        end
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= jsss_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and datapath
    always_comb begin
        logic                 div_start;
        logic signed [WA-1:0] div_a;

        div_start = 1'b0;
        div_a     = '0;
        store_we  = 1'b0;
        store_idx = sample_m1[MI-1:0];

        state_next        = state_reg;
        pos_tol_next      = pos_tol_reg;
        vel_tol_next      = vel_tol_reg;
        settle_ticks_next = settle_ticks_reg;
        bldc_range_next   = bldc_range_reg;
        dxl_range_next    = dxl_range_reg;
        armed_next        = armed_reg;
        motor_next        = motor_reg;
        kind_next         = kind_reg;
        target_next       = target_reg;
        timeout_next      = timeout_reg;
        elapsed_next      = elapsed_reg;
        settling_next     = settling_reg;
        settle_cnt_next   = settle_cnt_reg;
        op_next           = op_reg;
        cnt_next          = cnt_reg;
        dvd_next          = dvd_reg;
        rem_next          = rem_reg;
        neg_next          = neg_reg;
        cur_next          = cur_reg;
        vel_next          = vel_reg;
        tgt_mod_next      = tgt_mod_reg;
        err_next          = err_reg;
        nominal_next      = nominal_reg;
        kidx_next         = kidx_reg;
        found_next        = found_reg;
        best_next         = best_reg;
        bestd_next        = bestd_reg;
        m_valid_next      = m_valid_reg;
        m_kind_next       = m_kind_reg;
        m_angle_next      = m_angle_reg;
        m_last_next       = m_last_reg;
        pend_valid_next   = pend_valid_reg;
        pend_kind_next    = pend_kind_reg;

        // configuration writes, applied at once
        if (cfg_we) begin
            case (cfg_index)
                jsss_pkg::CFG_POS_TOL:    pos_tol_next      = cfg_wdata[TW-1:0];
                jsss_pkg::CFG_VEL_TOL:    vel_tol_next      = cfg_wdata[TW-1:0];
                jsss_pkg::CFG_SETTLE:     settle_ticks_next = cfg_wdata[TW-1:0];
                jsss_pkg::CFG_BLDC_RANGE: bldc_range_next   = cfg_wdata;
                jsss_pkg::CFG_DXL_RANGE:  dxl_range_next    = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            jsss_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (s_command)
                        jsss_pkg::CMD_START: begin
                            // arm a new step, replacing any armed one
                            motor_next      = s_motor_number;
                            kind_next       = s_motor_kind;
                            target_next     = s_target_angle;
                            timeout_next    = s_timeout_ticks;
                            elapsed_next    = '0;
                            settling_next   = 1'b0;
                            settle_cnt_next = '0;
                            armed_next      = 1'b1;
                            if (s_motor_kind == jsss_pkg::KIND_DXL) begin
                                m_valid_next = 1'b1;
                                m_kind_next  = jsss_pkg::RK_DXL_CMD;
                                m_angle_next = s_target_angle;
                                m_last_next  = 1'b1;
                                state_next   = jsss_pkg::ST_OUT;
                            end
                        end
                        jsss_pkg::CMD_SAMPLE: begin
                            store_we = sample_ok;
                        end
                        jsss_pkg::CMD_TICK: begin
                            if (armed_reg) begin
                                if (elapsed_reg != jsss_pkg::CNT_MAX) begin
                                    elapsed_next = elapsed_reg + 16'd1;
                                end
                                // snapshot the active joint; invalid motors read zero
                                cur_next = active_ok ? angle_store_reg[active_m1[MI-1:0]] : '0;
                                vel_next = active_ok ? vel_store_reg[active_m1[MI-1:0]] : '0;
                                div_start = 1'b1;
                                if (is_bldc) begin
                                    op_next = jsss_pkg::OP_CUR;
                                    div_a   = WA'(cur_next);
                                end else begin
                                    op_next = jsss_pkg::OP_TGT;
                                    div_a   = WA'(target_reg);
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            jsss_pkg::ST_DIV: begin
                dvd_next = dvd_reg << 1;
                rem_next = rem_step;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    state_next = jsss_pkg::ST_POST;
                end
            end

            jsss_pkg::ST_POST: begin
                case (op_reg)
                    jsss_pkg::OP_TGT: begin
                        tgt_mod_next = rem_pos;
                        op_next      = jsss_pkg::OP_CUR;
                        div_start    = 1'b1;
                        div_a        = WA'(cur_reg);
                    end
                    jsss_pkg::OP_CUR: begin
                        // phase error for bldc, wrapped difference otherwise
                        op_next   = jsss_pkg::OP_ERR;
                        div_start = 1'b1;
                        if (is_bldc) begin
                            div_a = WA'(target_reg) - $signed({{(WA - DW){1'b0}}, rem_pos});
                        end else begin
                            div_a = $signed({{(WA - DW){1'b0}}, tgt_mod_reg})
                                  - $signed({{(WA - DW){1'b0}}, rem_pos});
                        end
                    end
                    jsss_pkg::OP_ERR: begin
                        err_next   = fold_res;
                        state_next = is_bldc ? jsss_pkg::ST_NOM : jsss_pkg::ST_FIN;
                    end
                    default: begin
                        state_next = jsss_pkg::ST_IDLE;
                    end
                endcase
            end

            jsss_pkg::ST_NOM: begin
                nominal_next = WR'(cur_reg) + WR'(err_reg);
                kidx_next    = '0;
                found_next   = 1'b0;
                state_next   = jsss_pkg::ST_RAW;
            end

            jsss_pkg::ST_RAW: begin
                // strict compare keeps the lower k on a tie
                if (cand_fits && (!found_reg || cand_dist < bestd_reg)) begin
                    found_next = 1'b1;
                    best_next  = cand;
                    bestd_next = cand_dist;
                end
                kidx_next = kidx_reg + 3'd1;
                if (kidx_reg == 3'd4) begin
                    state_next = jsss_pkg::ST_FIN;
                end
            end

            jsss_pkg::ST_FIN: begin
                if (good) begin
                    settling_next   = 1'b1;
                    settle_cnt_next = settling_reg ? settle_inc : '0;
                end else begin
                    settling_next = 1'b0;
                end
                if (success || timed_out) begin
                    armed_next = 1'b0;
                end
                if (is_bldc) begin
                    m_valid_next    = 1'b1;
                    m_kind_next     = jsss_pkg::RK_BLDC_CMD;
                    m_angle_next    = raw_sel[ANGLE_BITS-1:0];
                    m_last_next     = !(success || timed_out);
                    pend_valid_next = success || timed_out;
                    pend_kind_next  = success ? jsss_pkg::RK_SUCCESS : jsss_pkg::RK_TIMEOUT;
                    state_next      = jsss_pkg::ST_OUT;
                end else if (success || timed_out) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = success ? jsss_pkg::RK_SUCCESS : jsss_pkg::RK_TIMEOUT;
                    m_angle_next = cur_reg;
                    m_last_next  = 1'b1;
                    state_next   = jsss_pkg::ST_OUT;
                end else begin
                    state_next = jsss_pkg::ST_IDLE;
                end
            end

            jsss_pkg::ST_OUT: begin
                if (m_ready) begin
                    if (pend_valid_reg) begin
                        // status item follows the bldc command
                        m_kind_next     = pend_kind_reg;
                        m_angle_next    = cur_reg;
                        m_last_next     = 1'b1;
                        pend_valid_next = 1'b0;
                    end else begin
                        m_valid_next = 1'b0;
                        state_next   = jsss_pkg::ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = jsss_pkg::ST_IDLE;
            end
        endcase

        // load the remainder unit with |dividend|
        if (div_start) begin
            neg_next   = div_a[WA-1];
            dvd_next   = div_a[WA-1] ? WA'(-div_a) : div_a;
            rem_next   = '0;
            cnt_next   = CW'(WA);
            state_next = jsss_pkg::ST_DIV;
        end
    end

    // control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_tol_reg      <= 16'd100;
            vel_tol_reg      <= 16'd20;
            settle_ticks_reg <= 16'd10;
            bldc_range_reg   <= 22'd142322;
            dxl_range_reg    <= 22'd108000;
            armed_reg        <= 1'b0;
            motor_reg        <= '0;
            kind_reg         <= '0;
            target_reg       <= '0;
            timeout_reg      <= '0;
            elapsed_reg      <= '0;
            settling_reg     <= 1'b0;
            settle_cnt_reg   <= '0;
            op_reg           <= jsss_pkg::OP_TGT;
            cnt_reg          <= '0;
            m_valid_reg      <= 1'b0;
            pend_valid_reg   <= 1'b0;
        end else begin
            pos_tol_reg      <= pos_tol_next;
            vel_tol_reg      <= vel_tol_next;
            settle_ticks_reg <= settle_ticks_next;
            bldc_range_reg   <= bldc_range_next;
            dxl_range_reg    <= dxl_range_next;
            armed_reg        <= armed_next;
            motor_reg        <= motor_next;
            kind_reg         <= kind_next;
            target_reg       <= target_next;
            timeout_reg      <= timeout_next;
            elapsed_reg      <= elapsed_next;
            settling_reg     <= settling_next;
            settle_cnt_reg   <= settle_cnt_next;
            op_reg           <= op_next;
            cnt_reg          <= cnt_next;
            m_valid_reg      <= m_valid_next;
            pend_valid_reg   <= pend_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        neg_reg       <= neg_next;
        cur_reg       <= cur_next;
        vel_reg       <= vel_next;
        tgt_mod_reg   <= tgt_mod_next;
        err_reg       <= err_next;
        nominal_reg   <= nominal_next;
        kidx_reg      <= kidx_next;
        found_reg     <= found_next;
        best_reg      <= best_next;
        bestd_reg     <= bestd_next;
        m_kind_reg    <= m_kind_next;
        m_angle_reg   <= m_angle_next;
        m_last_reg    <= m_last_next;
        pend_kind_reg <= pend_kind_next;
    end

    // joint stores, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_MOTORS; i++) begin
                angle_store_reg[i] <= '0;
                vel_store_reg[i]   <= '0;
            end
        end else if (store_we) begin
            angle_store_reg[store_idx] <= s_sample_angle;
            vel_store_reg[store_idx]   <= s_sample_velocity;
        end
    end

    // a result is only ever shown from the output state
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (state_reg == jsss_pkg::ST_OUT))
        else $error("result valid outside output state");

    // a dxl start gives its command item in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == jsss_pkg::CMD_START
         && s_motor_kind == jsss_pkg::KIND_DXL)
        |=> (m_valid && m_result_kind == jsss_pkg::RK_DXL_CMD && m_last_of_run))
        else $error("dxl start gave no command item");

    // a pending status item always sits behind a non-final bldc command
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (m_valid_reg && !m_last_reg
                            && m_kind_reg == jsss_pkg::RK_BLDC_CMD))
        else $error("pending status without bldc command");

    // the raw target search runs only for bldc steps
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == jsss_pkg::ST_RAW || state_reg == jsss_pkg::ST_NOM) |-> is_bldc)
        else $error("raw target search on non-bldc step");

endmodule

`default_nettype wire

/* test/tb.sv */
// tb: self-checking testbench of the joint step settle supervisor
// drives start, sample and tick items, predicts results in-line; depends on jsss_pkg
`timescale 1ns / 1ps

module tb;

    localparam int NMOT = 4;
    localparam int AW = 24;
    localparam int VW = jsss_pkg::VEL_W;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [1:0]           kind;
        logic [3:0]           motor;
        logic signed [AW-1:0] angle;
        logic                 last;
    } joint_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [jsss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [jsss_pkg::RANGE_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_command = '0;
    logic [3:0] s_motor_number = '0;
    logic [1:0] s_motor_kind = '0;
    logic signed [AW-1:0] s_target_angle = '0;
    logic [15:0] s_timeout_ticks = '0;
    logic signed [AW-1:0] s_sample_angle = '0;
    logic signed [VW-1:0] s_sample_velocity = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_result_kind;
    logic [3:0] m_result_motor;
    logic signed [AW-1:0] m_result_angle;
    logic m_last_of_run;

    joint_step_settle_supervisor #(.NUM_MOTORS(NMOT), .ANGLE_BITS(AW)) DUT (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predictor copy of configuration and step state
    longint pos_tol, vel_tol, settle_need, bldc_range, dxl_range;
    bit armed, settling_q;
    longint act_motor, act_kind, tgt, tmo, elapsed, settle_cnt;
    longint ang_store [NMOT];
    longint vel_store [NMOT];

    joint_result_t expected_results [$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;

    function automatic longint posmod(longint a, longint r);
        longint y;
        y = a % r;
        if (y < 0) y += r;
        return y;
    endfunction

    function automatic longint fold_err(longint d, longint r);
        longint e;
        e = d % r;
        if (2 * e > r) e -= r;
        if (2 * e < -r) e += r;
        return e;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit motor_valid(longint m);
        return m >= 1 && m <= NMOT;
    endfunction

    function automatic longint pick_raw_target(longint cur, longint err);
        longint nominal, best, best_d, c, d;
        bit found;
        nominal = cur + err;
        found = 0;
        best = 0;
        best_d = 0;
        for (int k = -2; k <= 2; k++) begin
            c = nominal + 72000 * k;
            if (2 * c < -bldc_range || 2 * c > bldc_range) continue;
            d = mag(c - cur);
            if (!found || d < best_d) begin
                found = 1;
                best_d = d;
                best = c;
            end
        end
        if (found) return best;
        return nominal < 0 ? -(bldc_range >>> 1) : (bldc_range >>> 1);
    endfunction

    task automatic queue_result(logic [1:0] kind, longint angle, bit last);
        joint_result_t r;
        r.kind = kind;
        r.motor = act_motor[3:0];
        r.angle = angle[AW-1:0];
        r.last = last;
        expected_results.insert(expected_results.size(), r);
    endtask

    // predict the results of one accepted item
    task automatic predict_item(logic [1:0] cmd, logic [3:0] mot, logic [1:0] kind,
                                logic signed [AW-1:0] ta, logic [15:0] to,
                                logic signed [AW-1:0] sa, logic signed [VW-1:0] sv);
        longint cur, vel, err, r;
        bit good, pending;
        if (cmd == jsss_pkg::CMD_START) begin
            act_motor = mot;
            act_kind = kind;
            tgt = ta;
            tmo = to;
            elapsed = 0;
            settling_q = 0;
            settle_cnt = 0;
            armed = 1;
            if (kind == jsss_pkg::KIND_DXL) queue_result(jsss_pkg::RK_DXL_CMD, tgt, 1);
        end else if (cmd == jsss_pkg::CMD_SAMPLE) begin
            if (motor_valid(mot)) begin
                ang_store[mot - 1] = sa;
                vel_store[mot - 1] = sv;
            end
        end else if (cmd == jsss_pkg::CMD_TICK && armed) begin
            if (elapsed < 65535) elapsed++;
            cur = motor_valid(act_motor) ? ang_store[act_motor - 1] : 0;
            vel = motor_valid(act_motor) ? vel_store[act_motor - 1] : 0;
            pending = 0;
            if (act_kind == jsss_pkg::KIND_BLDC) begin
                err = fold_err(tgt - posmod(cur, 72000), 72000);
                pending = 1;
            end else begin
                r = (act_motor == 1 || act_motor == 2) ? bldc_range : dxl_range;
                if (r == 0) r = 1;
                err = fold_err(posmod(tgt, r) - posmod(cur, r), r);
            end
            good = mag(err) <= pos_tol && mag(vel) <= vel_tol;
            // the raw command is last only if no status follows
            if (good && settling_q) begin
                if (settle_cnt < 65535) settle_cnt++;
            end
            if (good && settling_q && settle_cnt >= settle_need) begin
                if (pending) queue_result(jsss_pkg::RK_BLDC_CMD, pick_raw_target(cur, err), 0);
                queue_result(jsss_pkg::RK_SUCCESS, cur, 1);
                armed = 0;
            end else begin
                if (good && !settling_q) begin
                    settling_q = 1;
                    settle_cnt = 0;
                end else if (!good) begin
                    settling_q = 0;
                end
                if (elapsed >= tmo) begin
                    if (pending) queue_result(jsss_pkg::RK_BLDC_CMD,
                                              pick_raw_target(cur, err), 0);
                    queue_result(jsss_pkg::RK_TIMEOUT, cur, 1);
                    armed = 0;
                end else if (pending) begin
                    queue_result(jsss_pkg::RK_BLDC_CMD, pick_raw_target(cur, err), 1);
                end
            end
        end
    endtask

    // send one item, predicting its results on acceptance; valid stays high
    // until the next item or an idle cycle replaces it
    task automatic send_item(logic [1:0] cmd, logic [3:0] mot, logic [1:0] kind,
                             logic signed [AW-1:0] ta, logic [15:0] to,
                             logic signed [AW-1:0] sa, logic signed [VW-1:0] sv);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_motor_number <= mot;
        s_motor_kind <= kind;
        s_target_angle <= ta;
        s_timeout_ticks <= to;
        s_sample_angle <= sa;
        s_sample_velocity <= sv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_item(cmd, mot, kind, ta, to, sa, sv);
    endtask

    task automatic send_start(logic [3:0] mot, logic [1:0] kind, logic signed [AW-1:0] ta,
                              logic [15:0] to);
        send_item(jsss_pkg::CMD_START, mot, kind, ta, to, AW'($urandom), VW'($urandom));
    endtask

    task automatic send_sample(logic [3:0] mot, logic signed [AW-1:0] sa,
                               logic signed [VW-1:0] sv);
        send_item(jsss_pkg::CMD_SAMPLE, mot, 2'($urandom), AW'($urandom), 16'($urandom),
                  sa, sv);
    endtask

    task automatic send_tick();
        send_item(jsss_pkg::CMD_TICK, 4'($urandom), 2'($urandom), AW'($urandom),
                  16'($urandom), AW'($urandom), VW'($urandom));
    endtask

    // register writes only when idle; ticks can be silent, so wait out a tick's latency
    task automatic write_reg(logic [jsss_pkg::CFG_IDX_W-1:0] idx, longint value);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[jsss_pkg::RANGE_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            jsss_pkg::CFG_POS_TOL:    pos_tol = value & 16'hFFFF;
            jsss_pkg::CFG_VEL_TOL:    vel_tol = value & 16'hFFFF;
            jsss_pkg::CFG_SETTLE:     settle_need = value & 16'hFFFF;
            jsss_pkg::CFG_BLDC_RANGE: bldc_range = value & 22'h3FFFFF;
            default:                  dxl_range = value & 22'h3FFFFF;
        endcase
    endtask

    task automatic write_all(longint p, longint v, longint s, longint b, longint d);
        write_reg(jsss_pkg::CFG_POS_TOL, p);
        write_reg(jsss_pkg::CFG_VEL_TOL, v);
        write_reg(jsss_pkg::CFG_SETTLE, s);
        write_reg(jsss_pkg::CFG_BLDC_RANGE, b);
        write_reg(jsss_pkg::CFG_DXL_RANGE, d);
    endtask

    // result checker
    always @(posedge aclk) begin
        joint_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result: kind %0d motor %0d angle %0d last %0d",
                         $time, m_result_kind, m_result_motor, m_result_angle, m_last_of_run);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (want.kind !== m_result_kind || want.motor !== m_result_motor ||
                    want.angle !== m_result_angle || want.last !== m_last_of_run) begin
                    $display("%0t mismatch: expected kind %0d motor %0d angle %0d last %0d",
                             $time, want.kind, want.motor, want.angle, want.last);
                    $display("%0t           actual   kind %0d motor %0d angle %0d last %0d",
                             $time, m_result_kind, m_result_motor, m_result_angle,
                             m_last_of_run);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // directed: extremes, each command, invalid motors, wrap and raw limit cases
    task automatic test_directed();
        send_tick();                               // tick with nothing armed
        send_item(jsss_pkg::CMD_UNUSED, 4'hF, jsss_pkg::KIND_OTHER, '1, '1, '1, '1);
        send_sample(4'd1, 24'sh7FFFFF, 21'sh0FFFFF);
        send_sample(4'd2, -24'sh800000, -21'sh100000);
        send_sample(4'd0, 24'sd5, 21'sd5);         // ignored motor
        send_sample(4'd15, 24'sd5, 21'sd5);
        send_start(4'd1, jsss_pkg::KIND_BLDC, 24'sd100, 16'd1);
        send_tick();                               // bldc timeout, raw saturation
        send_start(4'd3, jsss_pkg::KIND_DXL, -24'sh800000, 16'd0);
        send_tick();
        send_start(4'd0, jsss_pkg::KIND_PLAIN, 24'sd0, 16'hFFFF);  // invalid motor reads zero
        send_sample(4'd3, 24'sd0, 21'sd0);
        repeat (3) send_tick();
        send_start(4'd4, jsss_pkg::KIND_OTHER, 24'sh7FFFFF, 16'd3);
        repeat (3) send_tick();
        send_sample(4'd2, 24'sd71990, 21'sd0);
        send_start(4'd2, jsss_pkg::KIND_BLDC, 24'sd35990, 16'd2);   // half-span fold
        repeat (2) send_tick();
    endtask

    task automatic random_step();
        logic [3:0] mot;
        logic [1:0] kind;
        int n;
        mot = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(1, NMOT));
        kind = 2'($urandom);
        send_start(mot, kind,
                   AW'($urandom_range(3) == 0 ? $urandom : $urandom_range(150000) - 75000),
                   16'($urandom_range(1, 20)));
        n = $urandom_range(2, 14);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(5))
                0: send_sample(4'($urandom), AW'($urandom), VW'($urandom));
                1, 2: send_sample(mot, AW'($urandom_range(300000) - 150000),
                                  VW'($urandom_range(40) - 20));
                default: send_tick();
            endcase
        end
    endtask

    task automatic test_random(int items);
        int start_n;
        start_n = 0;
        while (start_n < items) begin
            random_step();
            start_n += 9;
            if ($urandom_range(7) == 0) send_item(jsss_pkg::CMD_UNUSED, 4'($urandom),
                                                 2'($urandom), AW'($urandom),
                                                 16'($urandom), AW'($urandom),
                                                 VW'($urandom));
        end
    endtask

    task automatic set_idling(int s, int r);
        send_idle_pct = s;
        recv_stall_pct = r;
    endtask

    initial begin
        pos_tol = 100; vel_tol = 20; settle_need = 10; bldc_range = 142322; dxl_range = 108000;
        armed = 0; settling_q = 0; act_motor = 0; act_kind = 0; tgt = 0; tmo = 0;
        elapsed = 0; settle_cnt = 0;
        for (int i = 0; i < NMOT; i++) begin
            ang_store[i] = 0;
            vel_store[i] = 0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        write_all(0, 0, 0, 0, 0);
        test_directed();
        write_all(65535, 65535, 65535, 4194303, 4194303);
        test_directed();
        write_all(300, 30, 2, 142322, 108000);
        set_idling(0, 0);
        test_random(95);
        set_idling(75, 0);
        test_random(95);
        write_all(1000, 50, 1, 1, 36000);
        set_idling(0, 75);
        test_random(95);
        write_all(5000, 1000, 3, 72001, 1);
        set_idling(17, 17);
        test_random(95);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
